// ===== hdl/gls_pkg.sv =====
// ----------------------------------------------------------------------------
// gls_pkg
// Shared types and constants for the gate layer scheduler: the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gls_pkg;

    // Fixed widths of the transfer fields.
    localparam int unsigned MASK_IN_W = 16;
    localparam int unsigned INDEX_W   = 6;
    localparam int unsigned TOTAL_W   = 7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_gate;       // capture the gate and start the scan at the top layer
        logic scan_step;       // read the next lower layer
        logic set_target_hit;  // target is the layer after the one just read
        logic set_target_zero; // target is layer 0
        logic merge_write;     // OR the gate into the target layer
        logic open_write;      // open a new layer holding the gate
        logic set_ovf;         // record an overflow result
        logic load_out;        // move the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;            // layer just read overlaps the gate
        logic ptr_zero;       // layer just read is layer 0
        logic used_zero;      // no layer is in use
        logic target_lt_used; // target layer already exists
        logic used_full;      // every layer is in use
        logic out_free;       // output register can take a result this cycle
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/gls_datapath.sv =====
// ----------------------------------------------------------------------------
// gls_datapath
// Layer mask memory, scan pointer, layer count and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module gls_datapath #(
    parameter int unsigned MASK_W = 16,
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6,
    parameter int unsigned CNT_W  = 7
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire gls_pkg::cmd_t                cmd,
    output gls_pkg::status_t                  status,
    input  wire logic [MASK_W-1:0]            gate_in,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [gls_pkg::INDEX_W-1:0]       layer_index,
    output logic                              opened_layer,
    output logic                              overflow,
    output logic [gls_pkg::TOTAL_W-1:0]       layer_total
);

    logic [MASK_W-1:0] mem [DEPTH];
    logic [MASK_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [MASK_W-1:0] wr_data;
    logic              mem_we;

    logic [MASK_W-1:0] gate_reg;
    logic [ADDR_W-1:0] ptr_reg;
    logic [CNT_W-1:0]  target_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [CNT_W-1:0]  used_dec;
    logic [ADDR_W-1:0] ptr_dec;

    logic [CNT_W-1:0]  res_idx_reg;
    logic              res_open_reg;
    logic              res_ovf_reg;

    logic                        out_valid_reg;
    logic [gls_pkg::INDEX_W-1:0] out_index_reg;
    logic                        out_open_reg;
    logic                        out_ovf_reg;
    logic [gls_pkg::TOTAL_W-1:0] out_total_reg;

    assign used_dec = used_reg - CNT_W'(1);
    assign ptr_dec  = ptr_reg - ADDR_W'(1);

    always_comb
    begin
        if (cmd.load_gate)
        begin
            rd_addr = used_dec[ADDR_W-1:0];
        end
        else if (cmd.scan_step)
        begin
            rd_addr = ptr_dec;
        end
        else
        begin
            rd_addr = target_reg[ADDR_W-1:0];
        end
    end

    assign mem_we  = cmd.merge_write | cmd.open_write;
    assign wr_addr = cmd.open_write ? used_reg[ADDR_W-1:0] : target_reg[ADDR_W-1:0];
    assign wr_data = cmd.open_write ? gate_reg : (rd_data_reg | gate_reg);

    // Layer masks; data read from an entry at or above the layer count is never
    // used before the entry is written, so the memory needs no clearing.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_gate)
        begin
            gate_reg <= gate_in;
        end
        if (cmd.load_gate)
        begin
            ptr_reg <= used_dec[ADDR_W-1:0];
        end
        else if (cmd.scan_step)
        begin
            ptr_reg <= ptr_dec;
        end
        if (cmd.set_target_hit)
        begin
            target_reg <= CNT_W'(ptr_reg) + CNT_W'(1);
        end
        else if (cmd.set_target_zero)
        begin
            target_reg <= '0;
        end
        if (cmd.merge_write)
        begin
            res_idx_reg  <= target_reg;
            res_open_reg <= 1'b0;
            res_ovf_reg  <= 1'b0;
        end
        else if (cmd.open_write)
        begin
            res_idx_reg  <= used_reg;
            res_open_reg <= 1'b1;
            res_ovf_reg  <= 1'b0;
        end
        else if (cmd.set_ovf)
        begin
            res_idx_reg  <= '0;
            res_open_reg <= 1'b0;
            res_ovf_reg  <= 1'b1;
        end
        if (cmd.load_out)
        begin
            out_index_reg <= gls_pkg::INDEX_W'(res_idx_reg);
            out_open_reg  <= res_open_reg;
            out_ovf_reg   <= res_ovf_reg;
            out_total_reg <= gls_pkg::TOTAL_W'(used_reg);
        end
    end

    // Control state: layer count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.open_write)
            begin
                used_reg <= used_reg + CNT_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.hit            = |(rd_data_reg & gate_reg);
        status.ptr_zero       = (ptr_reg == '0);
        status.used_zero      = (used_reg == '0);
        status.target_lt_used = (target_reg < used_reg);
        status.used_full      = (used_reg == CNT_W'(DEPTH));
        status.out_free       = !out_valid_reg || !out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign layer_index  = out_index_reg;
    assign opened_layer = out_open_reg;
    assign overflow     = out_ovf_reg;
    assign layer_total  = out_total_reg;

endmodule

`default_nettype wire

// ===== hdl/gls_controller.sv =====
// ----------------------------------------------------------------------------
// gls_controller
// Sequences one gate: backward scan, resolve, merge, open or drop, and result.
// ----------------------------------------------------------------------------
`default_nettype none

module gls_controller (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire gls_pkg::status_t status,
    output gls_pkg::cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_RESOLVE = 5'b00100,
        ST_MERGE   = 5'b01000,
        ST_EMIT    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_gate = 1'b1;
                    if (status.used_zero)
                    begin
                        cmd.set_target_zero = 1'b1;
                        state_next          = ST_RESOLVE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                priority if (status.hit)
                begin
                    cmd.set_target_hit = 1'b1;
                    state_next         = ST_RESOLVE;
                end
                else if (status.ptr_zero)
                begin
                    cmd.set_target_zero = 1'b1;
                    state_next          = ST_RESOLVE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_RESOLVE:
            begin
                // The target layer is read here when it exists.
                priority if (status.target_lt_used)
                begin
                    state_next = ST_MERGE;
                end
                else if (!status.used_full)
                begin
                    cmd.open_write = 1'b1;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_MERGE:
            begin
                cmd.merge_write = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ===== hdl/gate_layer_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// gate_layer_scheduler_top
// As-soon-as-possible layering of a gate stream over per-layer qubit masks.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  -------------------------------------
//  in       input      in_valid / in_stall  qubit_mask
//  out      output     out_valid/out_stall  layer_index, opened_layer, overflow,
//                                           layer_total
//
//  After its transfer a gate passes through a backward scan of L layers, a
//  resolve step, a merge step only when it merges into an existing layer, and
//  the load of its result. L is 0 on an empty schedule and at most the layer
//  count, so up to MAX_LAYER_COUNT; the backward scan reads one layer mask per
//  cycle from a one-read one-write memory with a registered read, which sets
//  the rate.
//  The next gate is taken the cycle after the result is loaded.
//  Reset clears the layer count and the handshake state; no memory clearing
//  pass is needed, so a gate can be taken right after reset.
//  A stalled result holds the output register, and the block then waits with
//  its finished result before taking the next gate.
//
`default_nettype none

module gate_layer_scheduler_top #(
    parameter int unsigned NUM_QUBITS      = 16,
    parameter int unsigned MAX_LAYER_COUNT = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [gls_pkg::MASK_IN_W-1:0]  qubit_mask,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [gls_pkg::INDEX_W-1:0]         layer_index,
    output logic                                opened_layer,
    output logic                                overflow,
    output logic [gls_pkg::TOTAL_W-1:0]         layer_total
);

    // Only qubits below both NUM_QUBITS and the field width take part, so
    // the stored masks are that wide.
    localparam int unsigned MASK_W = (NUM_QUBITS < gls_pkg::MASK_IN_W) ?
                                     NUM_QUBITS : gls_pkg::MASK_IN_W;
    localparam int unsigned ADDR_W = (MAX_LAYER_COUNT > 1) ? $clog2(MAX_LAYER_COUNT) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_LAYER_COUNT + 1);

    gls_pkg::cmd_t    cmd;
    gls_pkg::status_t status;

    gls_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    gls_datapath #(
        .MASK_W (MASK_W),
        .DEPTH  (MAX_LAYER_COUNT),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .gate_in      (qubit_mask[MASK_W-1:0]),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .layer_index  (layer_index),
        .opened_layer (opened_layer),
        .overflow     (overflow),
        .layer_total  (layer_total)
    );

endmodule

`default_nettype wire

// ===== tb/sv/layer_schedule_checker.sv =====
// ----------------------------------------------------------------------------
// layer_schedule_checker
// Watches both channels of the gate layer scheduler. It keeps its own copy of
// the per-layer qubit occupancy, predicts the placement of every gate taken
// in, and compares each returned placement with the oldest prediction.
// ----------------------------------------------------------------------------
module layer_schedule_checker
    import gls_pkg::*;
#(
    parameter int unsigned NUM_QUBITS      = 16,
    parameter int unsigned MAX_LAYER_COUNT = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [MASK_IN_W-1:0] qubit_mask,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [INDEX_W-1:0]   layer_index,
    input  logic                 opened_layer,
    input  logic                 overflow,
    input  logic [TOTAL_W-1:0]   layer_total,
    output int                   fail_count,
    output int                   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               opened;
        logic               dropped;
        logic [TOTAL_W-1:0] total;
    } placement_t;

    // Only qubits below NUM_QUBITS take part in the overlap test.
    localparam logic [63:0] WIDE_WINDOW =
        (NUM_QUBITS >= 64) ? '1 : ((64'd1 << NUM_QUBITS) - 64'd1);

    logic [MASK_IN_W-1:0] occupancy [MAX_LAYER_COUNT];
    int unsigned          layers_in_use;
    placement_t           placements_due [$];
    placement_t           want;
    int                   mismatches;

    // Places one gate in the shadow schedule and returns the placement.
    function automatic placement_t place_gate(input logic [MASK_IN_W-1:0] raw);
        logic [MASK_IN_W-1:0] gate;
        int unsigned          target;
        int unsigned          i;
        logic                 found;
        placement_t           r;
        gate   = raw & WIDE_WINDOW[MASK_IN_W-1:0];
        target = 0;
        found  = 1'b0;
        r      = '0;
        for (i = layers_in_use; i > 0 && !found; i--)
        begin
            if ((occupancy[i-1] & gate) != '0)
            begin
                target = i;
                found  = 1'b1;
            end
        end
        if (target < layers_in_use)
        begin
            occupancy[target] = occupancy[target] | gate;
            r.index = target[INDEX_W-1:0];
        end
        else if (layers_in_use < MAX_LAYER_COUNT)
        begin
            occupancy[layers_in_use] = gate;
            r.index  = layers_in_use[INDEX_W-1:0];
            r.opened = 1'b1;
            layers_in_use++;
        end
        else
        begin
            r.dropped = 1'b1;
        end
        r.total = layers_in_use[TOTAL_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int expected);
        $display("%0t ns: placement mismatch on %s: got %0d, expected %0d",
                 $time, what, got, expected);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_LAYER_COUNT; k++)
                occupancy[k] = '0;
            layers_in_use = 0;
            mismatches    = 0;
            placements_due.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (placements_due.size() == 0)
                begin
                    report_mismatch("result transfer with nothing pending", 1, 0);
                end
                else
                begin
                    want = placements_due.pop_front();
                    if (layer_index !== want.index)
                        report_mismatch("layer_index", layer_index, want.index);
                    if (opened_layer !== want.opened)
                        report_mismatch("opened_layer", opened_layer, want.opened);
                    if (overflow !== want.dropped)
                        report_mismatch("overflow", overflow, want.dropped);
                    if (layer_total !== want.total)
                        report_mismatch("layer_total", layer_total, want.total);
                end
            end
            // A gate's result leaves through the scan and the output register, so it
            // never arrives in the cycle the gate was taken in.
            if (in_valid && !in_stall)
                placements_due.push_back(place_gate(qubit_mask));
            fail_count    <= mismatches;
            pending_count <= placements_due.size();
        end
    end

endmodule

// ===== tb/sv/tb_gate_layer_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// tb_gate_layer_scheduler_top
// Drives a stream of gates into the gate layer scheduler: a directed opening,
// random sparse circuits, a burst that fills every layer, and random gates
// against the full schedule. A checker beside the block predicts every
// placement; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_gate_layer_scheduler_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gls_pkg::*;

    localparam int unsigned QUBITS = 16;
    localparam int unsigned LAYERS = 64;

    // All inputs of the block start at known values.
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic [MASK_IN_W-1:0] qubit_mask   = '0;
    logic                 out_stall    = 1'b0;
    // While quiet is set, neither side inserts idle cycles.
    logic                 quiet        = 1'b0;

    logic                 in_stall;
    logic                 out_valid;
    logic [INDEX_W-1:0]   layer_index;
    logic                 opened_layer;
    logic                 overflow;
    logic [TOTAL_W-1:0]   layer_total;
    int                   fail_count;
    int                   pending_count;

    always #6 clk = ~clk;

    gate_layer_scheduler_top #(
        .NUM_QUBITS      (QUBITS),
        .MAX_LAYER_COUNT (LAYERS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .qubit_mask   (qubit_mask),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .layer_index  (layer_index),
        .opened_layer (opened_layer),
        .overflow     (overflow),
        .layer_total  (layer_total)
    );

    layer_schedule_checker #(
        .NUM_QUBITS      (QUBITS),
        .MAX_LAYER_COUNT (LAYERS)
    ) u_layer_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .qubit_mask    (qubit_mask),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .layer_index   (layer_index),
        .opened_layer  (opened_layer),
        .overflow      (overflow),
        .layer_total   (layer_total),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // The result side stalls at random about 15 percent of the time, except while
    // quiet is set. A stall may be raised at any time, including while a
    // result is waiting, so stalls land on every phase of the backward scan.
    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < 15);
    end

    // Offers one gate and returns once it has been taken. Idle cycles come
    // first, so the gate stays on the bus unchanged while it is stalled.
    task automatic send_gate(input logic [MASK_IN_W-1:0] mask);
        while (!quiet && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        qubit_mask <= mask;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Mostly sparse gates of one to three qubits, which build a schedule
    // layer by layer, plus some empty, full-width and arbitrary masks.
    function automatic logic [MASK_IN_W-1:0] random_gate();
        int unsigned          pick;
        int unsigned          nbits;
        logic [MASK_IN_W-1:0] g;
        pick = $urandom_range(99);
        g    = '0;
        if (pick < 4)
        begin
            g = '0;
        end
        else if (pick < 10)
        begin
            g = MASK_IN_W'($urandom);
        end
        else if (pick < 13)
        begin
            g = '1;
        end
        else
        begin
            nbits = $urandom_range(3, 1);
            repeat (nbits)
                g[$urandom_range(MASK_IN_W - 1)] = 1'b1;
        end
        return g;
    endfunction

    // Directed opening: an empty mask on an empty schedule opens layer 0, a
    // second empty mask lands there without opening, then the extremes of
    // the mask and gates that fit beside or stack on earlier ones.
    logic [MASK_IN_W-1:0] opening_gates [] = '{
        16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFE,
        16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF, 16'h0100, 16'h00FF,
        16'hFF00, 16'h8001
    };

    initial
    begin
        int unsigned burst_qubit;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_gates[k])
            send_gate(opening_gates[k]);

        // Random circuits. The first stretch runs with no idling on either
        // side so that back-to-back transfers are exercised.
        quiet <= 1'b1;
        for (int k = 0; k < 300; k++)
        begin
            if (k == 80)
                quiet <= 1'b0;
            send_gate(random_gate());
        end

        // Hold off the sender until every placement so far has been
        // returned, so the block also starts a gate from a fully idle state.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);

        // Repeated gates on one qubit stack one layer each, so this burst
        // fills every layer and then runs into overflow.
        burst_qubit = $urandom_range(QUBITS - 1);
        quiet <= 1'b1;
        repeat (70)
            send_gate(MASK_IN_W'(1) << burst_qubit);
        quiet <= 1'b0;

        // With every layer in use, gates clear of the burst qubit still fit
        // earlier layers while the rest are dropped.
        repeat (80)
            send_gate(random_gate());

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        // A full scan reads each layer in use at most once, so any stray result
        // would show up well within this window.
        repeat (LAYERS + 20) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("gate_layer_scheduler_top test passed");
        else
            $display("gate_layer_scheduler_top test failed");
        $finish;
    end

    // Watchdog: the slowest correct run is well under a millisecond.
    initial
    begin
        #8_000_000;
        $display("gate_layer_scheduler_top test failed");
        $finish;
    end

endmodule
